@@ hdl/ecefenu_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, tables and types for the ECEF to ENU rotation matrix block.
package ecefenu_pkg;

   localparam int DEFAULT_CORDIC_STAGES = 24;

   localparam int PHASE_W = 32;
   localparam int ANGLE_W = 32;
   localparam int ENTRY_W = 32;
   localparam int CORDIC_W = 34;

   // One full turn in degrees, 22 fraction bits
   localparam logic [31:0] DEG_TURN = 32'd1509949440;
   // ceil(2^37 / 45): exact floor(r / 45) for r below 2^31
   localparam logic [31:0] DEG_RECIP = 32'd3054198967;
   localparam int DEG_RECIP_SHIFT = 37;
   // round(2^33 / pi)
   localparam logic [31:0] RAD_TO_PHASE = 32'd2734261102;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] ONE_Q30 = 34'sd1073741824;

   typedef logic [7:0] deg_frac_tab_type [64];

   // floor((m * 128 + 22) / 45) for the remainder m of the divide by 45
   function automatic deg_frac_tab_type build_deg_frac_tab();
      deg_frac_tab_type t;
      for (int m = 0; m < 64; m++) begin
         t[m] = 8'(((m * 128) + 22) / 45);
      end
      return t;
   endfunction

   localparam deg_frac_tab_type DEG_FRAC_TAB = build_deg_frac_tab();

   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] v;
      case (i)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2FA;
         15:      v = 32'h0000517D;
         16:      v = 32'h000028BE;
         17:      v = 32'h0000145F;
         18:      v = 32'h00000A30;
         19:      v = 32'h00000518;
         20:      v = 32'h0000028C;
         21:      v = 32'h00000146;
         22:      v = 32'h000000A3;
         23:      v = 32'h00000051;
         24:      v = 32'h00000029;
         25:      v = 32'h00000014;
         26:      v = 32'h0000000A;
         27:      v = 32'h00000005;
         28:      v = 32'h00000003;
         29:      v = 32'h00000001;
         30:      v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/ecefenu_sincos.sv @@
`timescale 1ns / 1ps
// Pipelined sine/cosine of a 32-bit phase: quadrant split, CORDIC, saturate and rotate.
module ecefenu_sincos #(
   parameter int CORDIC_STAGES = ecefenu_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic        [ecefenu_pkg::PHASE_W-1:0]    phase,
   output logic signed [ecefenu_pkg::ENTRY_W-1:0]    cos_q,
   output logic signed [ecefenu_pkg::ENTRY_W-1:0]    sin_q
);

   localparam int CW = ecefenu_pkg::CORDIC_W;

   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] z_ff [CORDIC_STAGES+1];
   logic        [1:0]    q_ff [CORDIC_STAGES+1];

   logic [1:0]  q_in;
   logic [31:0] resid_in;
   logic [31:0] phase_rnd;

   // quadrant and residual in [-1/8, 1/8) turn
   always_comb begin
      phase_rnd = phase + 32'h20000000;
      q_in      = phase_rnd[31:30];
      resid_in  = phase - {q_in, 30'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= ecefenu_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= CW'($signed(resid_in));
         q_ff[0] <= q_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      localparam logic signed [CW-1:0] ATAN = CW'(ecefenu_pkg::atan_entry(i));
      logic signed [CW-1:0] x_in, y_in, z_in, dx, dy;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!z_ff[i][CW-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ATAN;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   logic signed [CW-1:0] c_sat, s_sat;
   logic signed [ecefenu_pkg::ENTRY_W-1:0] c_n, s_n, cos_in, sin_in;
   logic signed [ecefenu_pkg::ENTRY_W-1:0] cos_ff, sin_ff;

   always_comb begin
      c_sat = x_ff[CORDIC_STAGES];
      s_sat = y_ff[CORDIC_STAGES];
      if (c_sat > ecefenu_pkg::ONE_Q30)  c_sat = ecefenu_pkg::ONE_Q30;
      if (c_sat < -ecefenu_pkg::ONE_Q30) c_sat = -ecefenu_pkg::ONE_Q30;
      if (s_sat > ecefenu_pkg::ONE_Q30)  s_sat = ecefenu_pkg::ONE_Q30;
      if (s_sat < -ecefenu_pkg::ONE_Q30) s_sat = -ecefenu_pkg::ONE_Q30;
      c_n = ecefenu_pkg::ENTRY_W'(c_sat);
      s_n = ecefenu_pkg::ENTRY_W'(s_sat);
      case (q_ff[CORDIC_STAGES])
         2'd0: begin
            cos_in = c_n;
            sin_in = s_n;
         end
         2'd1: begin
            cos_in = -s_n;
            sin_in = c_n;
         end
         2'd2: begin
            cos_in = -c_n;
            sin_in = -s_n;
         end
         default: begin
            cos_in = s_n;
            sin_in = -c_n;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

@@ hdl/ecef_to_enu_rotation_matrix.sv @@
`timescale 1ns / 1ps
// Top level: ECEF to local east-north-up rotation matrix, fully pipelined.
//
// Usage: present a request (longitude, latitude, unit flag) on req_* with
// req_valid; it is taken at a rising edge where req_valid is high and
// req_stall is low. Each request yields one response on rsp_* carrying the
// nine matrix entries, row by row, as Q2.30 values (east_z is always zero).
// Request data passes through angle-to-phase conversion (range reduce,
// reciprocal or scale multiply, divide-by-45 fix-up, phase select), a
// quadrant split, a register stage per CORDIC iteration, saturate/rotate,
// product and round stages.
// Throughput is one request per cycle unless rsp_stall holds a response;
// the CORDIC iterations are unrolled into separate register stages.
// Reset clears the valid bits only; data registers are left as they are.
// When the receiver stalls a pending response, the whole pipeline holds and
// req_stall rises in the same cycle; bubbles in flight are held too.
module ecef_to_enu_rotation_matrix #(
   parameter int CORDIC_STAGES = ecefenu_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_longitude,
   input  logic signed [31:0]  req_latitude,
   input  logic                req_in_radians,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_east_x,
   output logic signed [31:0]  rsp_east_y,
   output logic                rsp_east_z,
   output logic signed [31:0]  rsp_north_x,
   output logic signed [31:0]  rsp_north_y,
   output logic signed [31:0]  rsp_north_z,
   output logic signed [31:0]  rsp_up_x,
   output logic signed [31:0]  rsp_up_y,
   output logic signed [31:0]  rsp_up_z
);

   localparam int LAT = CORDIC_STAGES + 8;

   logic en;
   logic vld_ff [LAT];

   // advance everything unless a finished response is held
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ---------------- angle to phase, per angle ----------------
   logic signed [31:0] ang_in [2];
   logic [31:0] phase_w [2];
   logic        rad_ff [3];

   assign ang_in[0] = req_longitude;
   assign ang_in[1] = req_latitude;

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0] <= req_in_radians;
         rad_ff[1] <= rad_ff[0];
         rad_ff[2] <= rad_ff[1];
      end
   end

   for (genvar a = 0; a < 2; a++) begin : g_ang
      logic signed [32:0] ax, turn;
      logic [30:0] r_in, r1_ff, r2_ff;
      logic signed [31:0] a1_ff;
      logic [62:0] pd_ff;
      logic [63:0] pr_ff, pr_rnd;
      logic signed [64:0] pr_in;
      logic [25:0] k_ff;
      logic [31:0] phr_ff, phd_in, ph_ff;
      logic [30:0] m_full;
      logic [5:0]  m;

      // stage 1: reduce degrees into [0, one turn)
      always_comb begin
         ax   = 33'(ang_in[a]);
         turn = $signed({1'b0, ecefenu_pkg::DEG_TURN});
         if (ax >= turn)        r_in = 31'(ax - turn);
         else if (!ax[32])      r_in = 31'(ax);
         else if (ax >= -turn)  r_in = 31'(ax + turn);
         else                   r_in = 31'(ax + turn + turn);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r1_ff <= r_in;
            a1_ff <= ang_in[a];
         end
      end

      // stage 2: reciprocal multiply for degrees, scale multiply for radians
      assign pr_in = $signed({{33{a1_ff[31]}}, a1_ff})
                   * $signed({33'b0, ecefenu_pkg::RAD_TO_PHASE});

      always_ff @(posedge clock) begin
         if (en) begin
            pd_ff <= 63'(r1_ff) * 63'(ecefenu_pkg::DEG_RECIP);
            pr_ff <= pr_in[63:0];
            r2_ff <= r1_ff;
         end
      end

      // stage 3: quotient by 45 and rounded radian phase
      assign pr_rnd = pr_ff + 64'h0000_0000_0080_0000;

      always_ff @(posedge clock) begin
         if (en) begin
            k_ff   <= pd_ff[62:ecefenu_pkg::DEG_RECIP_SHIFT];
            phr_ff <= pr_rnd[55:24];
         end
      end

      logic [30:0] r3_ff;
      always_ff @(posedge clock) begin
         if (en) r3_ff <= r2_ff;
      end

      // stage 4: remainder by 45 through the small table, select unit
      always_comb begin
         m_full = r3_ff - 31'(k_ff * 31'd45);
         m      = m_full[5:0];
         phd_in = 32'({k_ff, 7'b0}) + 32'(ecefenu_pkg::DEG_FRAC_TAB[m]);
      end

      always_ff @(posedge clock) begin
         if (en) ph_ff <= rad_ff[2] ? phr_ff : phd_in;
      end

      assign phase_w[a] = ph_ff;
   end

   // ---------------- sine and cosine ----------------
   logic signed [31:0] clon, slon, clat, slat;

   ecefenu_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lon (
      .clock (clock), .en (en), .phase (phase_w[0]), .cos_q (clon), .sin_q (slon)
   );

   ecefenu_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat (
      .clock (clock), .en (en), .phase (phase_w[1]), .cos_q (clat), .sin_q (slat)
   );

   // ---------------- products ----------------
   logic signed [63:0] p_nx_ff, p_ny_ff, p_ux_ff, p_uy_ff;
   logic signed [31:0] clon_ff, slon_ff, clat_ff, slat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_nx_ff <= slat * clon;
         p_ny_ff <= slat * slon;
         p_ux_ff <= clat * clon;
         p_uy_ff <= clat * slon;
         clon_ff <= clon;
         slon_ff <= slon;
         clat_ff <= clat;
         slat_ff <= slat;
      end
   end

   function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      logic signed [63:0] one;
      one = 64'sd1073741824;
      t   = (p + 64'sd536870912) >>> 30;
      if (t > one)  t = one;
      if (t < -one) t = -one;
      return 32'(t);
   endfunction

   logic signed [31:0] ex_ff, ey_ff, nx_ff, ny_ff, nz_ff, ux_ff, uy_ff, uz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ex_ff <= -slon_ff;
         ey_ff <= clon_ff;
         nx_ff <= -round_q30(p_nx_ff);
         ny_ff <= -round_q30(p_ny_ff);
         nz_ff <= clat_ff;
         ux_ff <= round_q30(p_ux_ff);
         uy_ff <= round_q30(p_uy_ff);
         uz_ff <= slat_ff;
      end
   end

   assign rsp_valid   = vld_ff[LAT-1];
   assign rsp_east_x  = ex_ff;
   assign rsp_east_y  = ey_ff;
   assign rsp_east_z  = 1'b0;
   assign rsp_north_x = nx_ff;
   assign rsp_north_y = ny_ff;
   assign rsp_north_z = nz_ff;
   assign rsp_up_x    = ux_ff;
   assign rsp_up_y    = uy_ff;
   assign rsp_up_z    = uz_ff;

   // ---------------- checks ----------------
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no response is held");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_up_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_up_z <= 32'sd1073741824 && rsp_up_z >= -32'sd1073741824))
      else $error("sine of latitude out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff[0]))
      else $error("pipeline moved during a stall");

endmodule
